// File: hdl/i2csrf_pkg.sv
package i2csrf_pkg;

	// Width of the register pointer as it is set over the bus (high and low byte).
	localparam int unsigned PTR_W = 16;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned DEF_STORE_DEPTH = 32;

	// Bus event codes; codes above OP_OTHER mean nothing and are handled like it.
	typedef enum logic [2:0] {
		OP_WR_MATCH = 3'd0,
		OP_RX_BYTE  = 3'd1,
		OP_RD_MATCH = 3'd2,
		OP_TX_NACK  = 3'd3,
		OP_STOP     = 3'd4,
		OP_OTHER    = 3'd5
	} op_e;

	// Position inside a write transfer: which data byte comes next.
	typedef enum logic [1:0] {
		BC_PTR_HIGH = 2'd0,
		BC_PTR_LOW  = 2'd1,
		BC_DATA     = 2'd2,
		BC_UNUSED   = 2'd3
	} byte_cnt_e;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_e;

	typedef struct packed {
		logic [2:0]        op;
		logic [DATA_W-1:0] rx_byte;
	} evt_t;

	typedef struct packed {
		logic              tx_valid;
		logic [DATA_W-1:0] tx_byte;
		logic              event_handled;
	} res_t;

	// Access to the register store for one cycle.
	typedef struct packed {
		logic              wr_en;
		logic [PTR_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
		logic              rd_en;
		logic [PTR_W-1:0]  rd_addr;
	} store_req_t;

endpackage

// File: hdl/i2c_slave_register_file.sv
// Path: a word accepted at a clock edge enters the store-read stage, then moves
// on into the output register on res when that register is free to take it.
// Throughput: one bus event word per cycle sustained; a new word is taken while
// a finished result waits, and outside the clearing pass the input stalls only
// when both the store-read stage and the output register are full.
// Reset: arst_n clears the pointer and byte count, then a clearing pass over
// every store entry zeroes the store, during which evt_stall stays high.
module i2c_slave_register_file
	import i2csrf_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	// The controller owns the write-transfer byte count, the latched high
	// pointer byte and the 16-bit register pointer. Every event is decoded in
	// the cycle it is accepted; a data byte in the third position is written
	// straight into the store when the pointer lies inside it.
	store_req_t        store_req;
	logic [DATA_W-1:0] store_rd_data;

	i2csrf_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (evt_valid),
		.evt_stall    (evt_stall),
		.evt          (evt),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.store_req    (store_req),
		.store_rd_data(store_rd_data)
	);

	// The store is a single synchronous memory with registered read data.
	// A read match issues its read at acceptance and the byte is picked up
	// in the output stage when the word moves on. Only one word enters per cycle, so
	// a write and a read never meet at the same edge.
	i2csrf_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.req    (store_req),
		.rd_data(store_rd_data)
	);

endmodule

// File: hdl/i2csrf_store.sv
module i2csrf_store
	import i2csrf_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic              clk,
	input  store_req_t        req,
	output logic [DATA_W-1:0] rd_data
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic [DATA_W-1:0] mem [STORE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
	end

	// Read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/i2csrf_ctrl.sv
module i2csrf_ctrl
	import i2csrf_pkg::*;
#(
	parameter int unsigned STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	input  evt_t              evt,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res,
	output store_req_t        store_req,
	input  logic [DATA_W-1:0] store_rd_data
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(STORE_DEPTH - 1);
	localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(STORE_DEPTH);

	state_e state_q, state_d;
	logic [AW-1:0] clr_addr_q;

	byte_cnt_e         bc_q, bc_d;
	logic [DATA_W-1:0] ptr_high_q, ptr_high_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;

	logic              s1_valid_q;
	logic              tx_valid_s1, in_range_s1, handled_s1;
	logic              tx_valid_d, handled_d;

	logic              res_valid_q;
	res_t              res_q;

	logic              accept, s1_move, in_range;
	logic [PTR_W:0]    ptr_inc;

	assign in_range = {1'b0, ptr_q} < DEPTH_EXT;
	assign ptr_inc  = {1'b0, ptr_q} + (PTR_W + 1)'(1);
	assign s1_move  = s1_valid_q && (!res_valid_q || !res_stall);
	assign evt_stall = (state_q != ST_RUN) || (s1_valid_q && !s1_move);
	assign accept   = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		bc_d       = bc_q;
		ptr_high_d = ptr_high_q;
		ptr_d      = ptr_q;
		tx_valid_d = 1'b0;
		handled_d  = 1'b1;
		store_req  = '0;

		case (state_q)
			ST_CLEAR: begin
				store_req.wr_en   = 1'b1;
				store_req.wr_addr = PTR_W'(clr_addr_q);
				store_req.wr_data = '0;
				if (clr_addr_q == CLR_LAST) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				store_req.wr_addr = ptr_q;
				store_req.wr_data = evt.rx_byte;
				store_req.rd_addr = ptr_q;
				if (accept) begin
					case (evt.op)
						OP_WR_MATCH, OP_STOP: begin
							bc_d = BC_PTR_HIGH;
						end
						OP_RX_BYTE: begin
							case (bc_q)
								BC_PTR_LOW: begin
									ptr_d = {ptr_high_q, evt.rx_byte};
									bc_d  = BC_DATA;
								end
								BC_DATA: begin
									store_req.wr_en = in_range;
									bc_d            = BC_PTR_HIGH;
								end
								default: begin
									ptr_high_d = evt.rx_byte;
									bc_d       = BC_PTR_LOW;
								end
							endcase
						end
						OP_RD_MATCH: begin
							tx_valid_d      = 1'b1;
							store_req.rd_en = in_range;
							if (!in_range || ptr_inc >= DEPTH_EXT) begin
								ptr_d = '0;
							end else begin
								ptr_d = ptr_inc[PTR_W-1:0];
							end
						end
						OP_TX_NACK: begin
						end
						default: begin
							handled_d = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= BC_PTR_HIGH;
			ptr_high_q  <= '0;
			ptr_q       <= '0;
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			bc_q       <= bc_d;
			ptr_high_q <= ptr_high_d;
			ptr_q      <= ptr_d;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tx_valid_s1 <= tx_valid_d;
			in_range_s1 <= in_range;
			handled_s1  <= handled_d;
		end
		if (s1_move) begin
			res_q.tx_valid      <= tx_valid_s1;
			res_q.tx_byte       <= (tx_valid_s1 && in_range_s1) ? store_rd_data : '0;
			res_q.event_handled <= handled_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: tb/tb_i2c_slave_register_file.sv
module tb_i2c_slave_register_file;
	import i2csrf_pkg::*;

	localparam int unsigned STORE_DEPTH = DEF_STORE_DEPTH;
	localparam int unsigned AW = $clog2(STORE_DEPTH);

	// Codes 6 and 7 have no name in the package, but the bus may still deliver them.
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// Random traffic is queued until this many bus events with a meaning have been queued.
	localparam int unsigned EVENT_TARGET = 1350;

	// The run fails after this many cycles in which neither channel moves a word.
	// The longest correct quiet stretch is the clearing pass after reset, or one
	// sender gap plus one receiver stall plus the pipeline. Both are far below this.
	localparam int unsigned QUIET_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	i2c_slave_register_file #(
		.STORE_DEPTH(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bus events waiting to be driven, and the replies that the slave owes for
	// the events it has already taken, oldest first.
	evt_t pending_events[$];
	res_t pending_replies[$];
	int unsigned meaningful_events = 0;

	// Our own view of the slave's state. It starts out as the reset state:
	// the byte count and pointers are zero, and the store is cleared.
	byte_cnt_e shadow_count = BC_PTR_HIGH;
	logic [DATA_W-1:0] shadow_ptr_high = '0;
	logic [PTR_W-1:0] shadow_ptr = '0;
	logic [DATA_W-1:0] shadow_regs[STORE_DEPTH];

	int unsigned words_taken = 0;
	int unsigned reads_total = 0;
	int unsigned reads_outside = 0;
	int unsigned writes_stored = 0;
	int unsigned writes_dropped = 0;
	int unsigned mismatches = 0;

	// Handshake flags from the last rising edge. The falling-edge processes use
	// them to decide what to drive next.
	logic evt_taken;
	logic res_taken;

	// Pacing for each side: 0 runs flat out, 1 waits briefly, 2 idles heavily.
	// The mode changes now and then, so the run alternates between back-to-back
	// traffic and heavy idling.
	int evt_pace = 0;
	int res_pace = 0;
	int unsigned evt_gap = 0;
	int unsigned res_hold = 0;
	int unsigned quiet_cycles = 0;

	function automatic int unsigned draw_wait(inout int pace);
		if ($urandom_range(0, 40) == 0)
			pace = $urandom_range(0, 2);
		case (pace)
			0: return 0;
			1: return $urandom_range(0, 2);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Applies one bus event to the shadow state and returns the reply that the
	// slave must give for it.
	function automatic res_t slave_respond(input evt_t e);
		res_t r;
		r = '0;
		r.event_handled = 1'b1;
		case (e.op)
			OP_WR_MATCH, OP_STOP: begin
				shadow_count = BC_PTR_HIGH;
			end
			OP_RX_BYTE: begin
				case (shadow_count)
					BC_PTR_LOW: begin
						shadow_ptr = {shadow_ptr_high, e.rx_byte};
						shadow_count = BC_DATA;
					end
					BC_DATA: begin
						// The third byte lands in the store only when the pointer
						// is inside the store. The count restarts either way.
						if (shadow_ptr < STORE_DEPTH) begin
							shadow_regs[shadow_ptr[AW-1:0]] = e.rx_byte;
							writes_stored++;
						end else begin
							writes_dropped++;
						end
						shadow_count = BC_PTR_HIGH;
					end
					default: begin
						shadow_ptr_high = e.rx_byte;
						shadow_count = BC_PTR_LOW;
					end
				endcase
			end
			OP_RD_MATCH: begin
				r.tx_valid = 1'b1;
				reads_total++;
				if (shadow_ptr < STORE_DEPTH) begin
					r.tx_byte = shadow_regs[shadow_ptr[AW-1:0]];
					shadow_ptr = (shadow_ptr + 1 >= STORE_DEPTH) ? '0 :
						PTR_W'(shadow_ptr + 1);
				end else begin
					// A read outside the store returns zero and sends the
					// pointer back to the first entry.
					reads_outside++;
					shadow_ptr = '0;
				end
			end
			OP_TX_NACK: begin
			end
			default: begin
				r.event_handled = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic push_event(input logic [2:0] op, input logic [DATA_W-1:0] data);
		evt_t e;
		e.op = op;
		e.rx_byte = data;
		pending_events.push_back(e);
		if (op <= OP_STOP)
			meaningful_events++;
	endtask

	function automatic logic [DATA_W-1:0] rand_byte();
		return DATA_W'($urandom_range(0, 255));
	endfunction

	// Most pointers fall inside the store. Some have a zero high byte and any low
	// byte, and some are drawn from the full 16-bit range.
	function automatic logic [PTR_W-1:0] pick_pointer();
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind < 14)
			return PTR_W'($urandom_range(0, STORE_DEPTH - 1));
		else if (kind < 17)
			return PTR_W'($urandom_range(0, 255));
		else
			return PTR_W'($urandom_range(0, 65535));
	endfunction

	task automatic set_pointer(input logic [PTR_W-1:0] ptr);
		push_event(OP_WR_MATCH, rand_byte());
		push_event(OP_RX_BYTE, ptr[15:8]);
		push_event(OP_RX_BYTE, ptr[7:0]);
	endtask

	// Builds the random traffic. Most of it is well-formed write and read
	// transfers with random pointers and data. The rest is cut-short writes
	// and raw noise that uses every event code, the spare ones included.
	task automatic build_random_traffic();
		int unsigned pick;
		int unsigned burst;
		logic [PTR_W-1:0] ptr;
		while (meaningful_events < EVENT_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				ptr = pick_pointer();
				set_pointer(ptr);
				push_event(OP_RX_BYTE, rand_byte());
				if ($urandom_range(0, 1))
					push_event(OP_STOP, rand_byte());
			end else if (pick < 8) begin
				if ($urandom_range(0, 2) != 0) begin
					ptr = pick_pointer();
					set_pointer(ptr);
					// Sometimes the read follows as a repeated start, and
					// sometimes after a full stop.
					if ($urandom_range(0, 1))
						push_event(OP_STOP, rand_byte());
				end
				burst = $urandom_range(1, 6);
				repeat (burst)
					push_event(OP_RD_MATCH, rand_byte());
				push_event(OP_TX_NACK, rand_byte());
				push_event(OP_STOP, rand_byte());
			end else if (pick == 8) begin
				push_event(OP_WR_MATCH, rand_byte());
				burst = $urandom_range(0, 1);
				repeat (burst + 1)
					push_event(OP_RX_BYTE, rand_byte());
				push_event($urandom_range(0, 1) ? OP_STOP : OP_WR_MATCH, rand_byte());
			end else begin
				burst = $urandom_range(1, 4);
				repeat (burst)
					push_event(3'($urandom_range(0, 7)), rand_byte());
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Event driver. It presents the next queued word at the falling edge once
	// the current one has been taken and the drawn gap has run out. A word is
	// held steady for as long as the slave stalls it.
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else if (!evt_valid || evt_taken) begin
			if (evt_gap > 0) begin
				evt_gap <= evt_gap - 1;
				evt_valid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				evt <= pending_events.pop_front();
				evt_valid <= 1'b1;
				evt_gap <= draw_wait(evt_pace);
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// Reply receiver. After each accepted reply it draws how many cycles to
	// stall before it takes the next one. The stall is counted in cycles
	// whether or not a reply is waiting, so that it falls on every pipeline
	// phase.
	always @(negedge clk) begin : reply_pacing
		int unsigned hold;
		hold = res_taken ? draw_wait(res_pace) : res_hold;
		if (hold > 0) begin
			res_stall <= 1'b1;
			res_hold <= hold - 1;
		end else begin
			res_stall <= 1'b0;
			res_hold <= 0;
		end
	end

	// Monitor. At each rising edge it checks an accepted reply against the
	// oldest expected one, then predicts the reply to any event taken at the
	// same edge. The reply to an event can never leave at the edge that takes
	// the event, so doing the check first is safe.
	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			evt_taken <= 1'b0;
			res_taken <= 1'b0;
		end else begin
			evt_taken <= evt_valid && !evt_stall;
			res_taken <= res_valid && !res_stall;
			if (res_valid && !res_stall) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: reply with none expected, expected nothing, actual %p",
						$time, res);
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					check_field("tx_valid", 32'(want.tx_valid), 32'(res.tx_valid));
					check_field("tx_byte", 32'(want.tx_byte), 32'(res.tx_byte));
					check_field("event_handled", 32'(want.event_handled),
						32'(res.event_handled));
				end
			end
			if (evt_valid && !evt_stall) begin
				pending_replies.push_back(slave_respond(evt));
				words_taken++;
			end
		end
	end

	// Watchdog. It counts cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("tb_i2c_slave_register_file: done, errors");
				$finish;
			end
		end
	end

	initial begin
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;

		// Directed opening. First a read straight out of reset, which sees
		// the cleared store at pointer zero.
		push_event(OP_RD_MATCH, 8'h00);
		// The write at the last entry uses an all-ones data byte. Then the
		// pointer is set back to the last entry and read, so that it wraps to
		// zero.
		set_pointer(PTR_W'(STORE_DEPTH - 1));
		push_event(OP_RX_BYTE, 8'hFF);
		set_pointer(PTR_W'(STORE_DEPTH - 1));
		push_event(OP_RD_MATCH, 8'hFF);
		push_event(OP_STOP, 8'h00);
		// A write at the highest pointer is dropped, and a read there returns
		// zero and resets the pointer.
		set_pointer(16'hFFFF);
		push_event(OP_RX_BYTE, 8'hAA);
		push_event(OP_RD_MATCH, 8'h00);
		// A pointer one past the end behaves the same way for reads.
		set_pointer(PTR_W'(STORE_DEPTH));
		push_event(OP_RD_MATCH, 8'h55);
		push_event(OP_TX_NACK, 8'h00);
		// The event codes the slave does not handle leave its state alone.
		push_event(OP_OTHER, 8'hFF);
		push_event(OP_SPARE_6, 8'h00);
		push_event(OP_SPARE_7, 8'hFF);
		push_event(OP_RD_MATCH, 8'h00);

		build_random_traffic();

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last event to be taken and the last reply to be checked.
		// Then allow a few more cycles for any reply that should not appear.
		@(posedge clk);
		while (pending_events.size() > 0 || evt_valid || pending_replies.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d bus events: %0d reads (%0d outside the store),",
			words_taken, reads_total, reads_outside);
		$display("%0d writes stored, %0d dropped.", writes_stored, writes_dropped);
		if (mismatches == 0)
			$display("tb_i2c_slave_register_file: done, clean");
		else
			$display("tb_i2c_slave_register_file: done, errors");
		$finish;
	end

endmodule
